[src/swmf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sliding window median filter.
// No dependencies; every other file of the block refers to this package by scoped names.
package swmf_pkg;

   // Default sizes handed to the top level parameters
   parameter int MAX_WINDOW_DEF  = 32;
   parameter int SAMPLE_BITS_DEF = 16;

   // Configuration port layout
   parameter int CFG_BITS      = 6;
   parameter int CSR_ADDR_BITS = 3;
   parameter int CSR_DATA_BITS = 32;

   // Register index (paddr word select) and reset value
   parameter logic [CSR_ADDR_BITS-3:0] REG_WINDOW_LENGTH   = 1'b0;
   parameter logic [CFG_BITS-1:0]      WINDOW_LENGTH_RESET = 6'd3;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FEED,
      ST_SETTLE,
      ST_PICK,
      ST_EMIT
   } state_type;

   // Commands broadcast to every sorter cell
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } sort_ctrl_type;

endpackage

[src/swmf_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample items and result items.
// Depends on swmf_pkg for default widths.
interface swmf_req_if #(
   parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swmf_rsp_if #(
   parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_BITS:0] median_x2;
   logic                        last_result;

   modport source (output valid, output median_x2, output last_result, input ready);
   modport sink   (input valid, input median_x2, input last_result, output ready);
endinterface

[src/swmf_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on swmf_pkg for default sizes; used for the sample window store.
module swmf_ram #(
   parameter int WIDTH = swmf_pkg::SAMPLE_BITS_DEF,
   parameter int DEPTH = swmf_pkg::MAX_WINDOW_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/swmf_sort_cell.sv]
`timescale 1ns / 1ps
// One cell of the insertion sorter: holds one value, kept in ascending order along the row.
// Depends on swmf_pkg for the command struct.
module swmf_sort_cell #(
   parameter int WIDTH = swmf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swmf_pkg::sort_ctrl_type ctrl,
   input  logic signed [WIDTH-1:0] x,
   input  logic                    left_gt,
   input  logic signed [WIDTH-1:0] left_value,
   input  logic                    left_valid,
   input  logic signed [WIDTH-1:0] right_value,
   input  logic                    right_valid,
   output logic signed [WIDTH-1:0] value,
   output logic                    valid,
   output logic                    gt
);

   logic signed [WIDTH-1:0] value_ff, value_in;
   logic                    valid_ff, valid_in;

   // new item goes at or before this cell; an empty cell counts as +infinity
   assign gt = !valid_ff || (x < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert) begin
         if (gt) begin
            if (left_gt) begin
               // make room: take the left neighbor's value
               value_in = left_value;
               valid_in = left_valid;
            end else begin
               value_in = x;
               valid_in = 1'b1;
            end
         end
      end else if (ctrl.shift) begin
         // shift out toward cell 0
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

[src/swmf_sort_chain.sv]
`timescale 1ns / 1ps
// Row of sorter cells: broadcast insertion, then shift-out of ranks through cell 0.
// Depends on swmf_pkg and swmf_sort_cell.
module swmf_sort_chain #(
   parameter int DEPTH = swmf_pkg::MAX_WINDOW_DEF,
   parameter int WIDTH = swmf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swmf_pkg::sort_ctrl_type ctrl,
   input  logic signed [WIDTH-1:0] x,
   output logic signed [WIDTH-1:0] head_value
);

   logic signed [WIDTH-1:0] value_w [DEPTH];
   logic                    valid_w [DEPTH];
   logic                    gt_w    [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                    l_gt;
      logic signed [WIDTH-1:0] l_value;
      logic                    l_valid;
      logic signed [WIDTH-1:0] r_value;
      logic                    r_valid;

      // left neighbor (cell 0 has none; it takes the new item itself when the item goes at or before it)
      if (i == 0) begin : g_first
         assign l_gt    = 1'b0;
         assign l_value = x;
         assign l_valid = 1'b1;
      end else begin : g_mid
         assign l_gt    = gt_w[i-1];
         assign l_value = value_w[i-1];
         assign l_valid = valid_w[i-1];
      end

      // right neighbor (the end of the row shifts in an empty slot)
      if (i == DEPTH - 1) begin : g_last
         assign r_value = '0;
         assign r_valid = 1'b0;
      end else begin : g_next
         assign r_value = value_w[i+1];
         assign r_valid = valid_w[i+1];
      end

      swmf_sort_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .x          (x),
         .left_gt    (l_gt),
         .left_value (l_value),
         .left_valid (l_valid),
         .right_value(r_value),
         .right_valid(r_valid),
         .value      (value_w[i]),
         .valid      (valid_w[i]),
         .gt         (gt_w[i])
      );
   end

   assign head_value = value_w[0];

endmodule

[src/sliding_window_median_filter.sv]
`timescale 1ns / 1ps
// Top level of the sliding window median filter: controller, window store, sorter, CSR.
// Depends on swmf_pkg, swmf_if, swmf_ram and swmf_sort_chain.
//
//   channel   direction  handshake         payload
//   req_chan  in         valid/ready       sample, last_sample
//   rsp_chan  out        valid/ready       median_x2, last_result
//   csr_*     in         APB write/read    window_length (byte address 0)
//
// For each item the controller accepts it, then for each result that it can give loads the
// sorter row with the n samples of that result's window through the single RAM read port,
// lets the row settle, shifts ranks out of cell 0 up to the middle rank, and emits.
// Steady state with window k gives one result per item.
// Reset is synchronous; the window store is not cleared. A stalled result waits in the
// output register; the next item is accepted meanwhile and stalls only at its own emit.
module sliding_window_median_filter #(
   parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   swmf_req_if.sink                           req_chan,
   swmf_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [swmf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [swmf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [swmf_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int KW = $clog2(MAX_WINDOW + 1);
   localparam int CW = KW + 1;
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int EW = (CW > swmf_pkg::CFG_BITS) ? CW : swmf_pkg::CFG_BITS;
   localparam int CB = swmf_pkg::CFG_BITS;
   localparam int DB = swmf_pkg::CSR_DATA_BITS;
   localparam int AB = swmf_pkg::CSR_ADDR_BITS;

   // ---------------------------------------------------------------------------------
   // Configuration register
   logic [CB-1:0] window_length_ff;
   logic          csr_sel;

   assign csr_sel    = (csr_paddr[AB-1:2] == swmf_pkg::REG_WINDOW_LENGTH);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_sel ? {{(DB-CB){1'b0}}, window_length_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= swmf_pkg::WINDOW_LENGTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel) begin
         window_length_ff <= csr_pwdata[CB-1:0];
      end
   end

   // effective k clamped to 1 .. MAX_WINDOW, with its half widths
   logic [EW-1:0] wl_wide;
   logic [EW-1:0] k_wide;
   logic [KW-1:0] k, rh, lh;

   assign wl_wide = EW'(window_length_ff);
   always_comb begin
      if (wl_wide == '0) begin
         k_wide = EW'(1);
      end else if (wl_wide > EW'(MAX_WINDOW)) begin
         k_wide = EW'(MAX_WINDOW);
      end else begin
         k_wide = wl_wide;
      end
   end
   assign k  = KW'(k_wide);
   assign rh = k >> 1;
   assign lh = KW'(k - 1'b1) >> 1;

   // ---------------------------------------------------------------------------------
   // Controller registers
   swmf_pkg::state_type state_ff, state_in;
   logic [KW-1:0]       seen_ff, seen_in;
   logic [KW-1:0]       pend_ff, pend_in;
   logic                last_ff, last_in;
   logic [AW-1:0]       head_ff, head_in;
   logic                rd_pend_ff;
   logic [AW-1:0]       a_ff, a_in;
   logic [KW-1:0]       cnt_ff, cnt_in;
   logic [KW-1:0]       mid_ff, mid_in;
   logic                even_ff, even_in;
   logic [KW-1:0]       r_ff, r_in;
   logic                res_last_ff, res_last_in;
   logic signed [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic signed [SAMPLE_BITS-1:0] hi_ff, hi_in;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS:0]   rsp_median_ff;
   logic                          rsp_last_ff;

   // control strobes
   logic                    req_accept;
   logic                    emit_ok;
   logic                    rd_en;
   swmf_pkg::sort_ctrl_type sort_ctrl;
   logic signed [SAMPLE_BITS-1:0] sort_head;
   logic [SAMPLE_BITS-1:0]        rd_data;

   // ---------------------------------------------------------------------------------
   // Window planning for the oldest pending item
   logic          has_result;
   logic [KW-1:0] d, right_k, left_k, right_sel, n;
   logic [CW-1:0] left_sum, left_c1;

   assign has_result = (pend_ff != '0) && (last_ff || (pend_ff > rh));
   assign d          = KW'(pend_ff - 1'b1);
   assign right_k    = (d > rh) ? KW'(d - rh) : '0;
   always_comb begin
      left_sum = CW'(d) + CW'(lh);
      left_c1  = (left_sum > CW'(KW'(seen_ff - 1'b1))) ? CW'(KW'(seen_ff - 1'b1)) : left_sum;
      left_k   = (left_c1 > CW'(MAX_WINDOW - 1)) ? KW'(MAX_WINDOW - 1) : KW'(left_c1);
   end
   assign right_sel = (right_k > left_k) ? left_k : right_k;
   assign n         = KW'(left_k - right_sel + 1'b1);

   // ---------------------------------------------------------------------------------
   // Circular store addressing: offset a from the newest sample
   logic [AW-1:0] head_next;
   logic [CW-1:0] pos_sum;
   logic [AW-1:0] rd_addr;

   assign head_next = (head_ff == AW'(MAX_WINDOW - 1)) ? '0 : AW'(head_ff + 1'b1);
   assign pos_sum   = CW'(head_ff) + CW'(MAX_WINDOW) - CW'(a_ff);
   assign rd_addr   = (pos_sum >= CW'(MAX_WINDOW)) ? AW'(pos_sum - CW'(MAX_WINDOW))
                                                  : AW'(pos_sum);

   // ---------------------------------------------------------------------------------
   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swmf_pkg::ST_IDLE: begin
            if (req_chan.valid) state_in = swmf_pkg::ST_CHECK;
         end
         swmf_pkg::ST_CHECK: begin
            state_in = has_result ? swmf_pkg::ST_FEED : swmf_pkg::ST_IDLE;
         end
         swmf_pkg::ST_FEED: begin
            if (cnt_ff == KW'(1)) state_in = swmf_pkg::ST_SETTLE;
         end
         swmf_pkg::ST_SETTLE: begin
            state_in = swmf_pkg::ST_PICK;
         end
         swmf_pkg::ST_PICK: begin
            if (r_ff == mid_ff) state_in = swmf_pkg::ST_EMIT;
         end
         swmf_pkg::ST_EMIT: begin
            if (emit_ok) state_in = swmf_pkg::ST_CHECK;
         end
         default: begin
            state_in = swmf_pkg::ST_IDLE;
         end
      endcase
   end

   // Controller outputs
   always_comb begin
      req_chan.ready   = 1'b0;
      rd_en            = 1'b0;
      sort_ctrl.clear  = 1'b0;
      sort_ctrl.shift  = 1'b0;
      sort_ctrl.insert = rd_pend_ff;
      case (state_ff)
         swmf_pkg::ST_IDLE:  req_chan.ready  = 1'b1;
         swmf_pkg::ST_CHECK: sort_ctrl.clear = 1'b1;
         swmf_pkg::ST_FEED:  rd_en           = 1'b1;
         swmf_pkg::ST_PICK:  sort_ctrl.shift = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_accept = req_chan.valid && (state_ff == swmf_pkg::ST_IDLE);
   assign emit_ok    = (state_ff == swmf_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // Datapath next values
   always_comb begin
      seen_in     = seen_ff;
      pend_in     = pend_ff;
      last_in     = last_ff;
      head_in     = head_ff;
      a_in        = a_ff;
      cnt_in      = cnt_ff;
      mid_in      = mid_ff;
      even_in     = even_ff;
      r_in        = r_ff;
      res_last_in = res_last_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      case (state_ff)
         swmf_pkg::ST_IDLE: begin
            if (req_accept) begin
               head_in = head_next;
               last_in = req_chan.last_sample;
               if (seen_ff != KW'(MAX_WINDOW)) seen_in = KW'(seen_ff + 1'b1);
               if (pend_ff != KW'(MAX_WINDOW)) pend_in = KW'(pend_ff + 1'b1);
            end
         end
         swmf_pkg::ST_CHECK: begin
            if (has_result) begin
               pend_in     = d;
               a_in        = AW'(right_sel);
               cnt_in      = n;
               mid_in      = n >> 1;
               even_in     = !n[0];
               r_in        = '0;
               res_last_in = last_ff && (pend_ff == KW'(1));
            end else if (last_ff) begin
               // end of signal: next item starts a new one
               seen_in = '0;
               pend_in = '0;
               last_in = 1'b0;
            end
         end
         swmf_pkg::ST_FEED: begin
            a_in   = AW'(a_ff + 1'b1);
            cnt_in = KW'(cnt_ff - 1'b1);
         end
         swmf_pkg::ST_PICK: begin
            // cell 0 holds rank r_ff of the window
            r_in = KW'(r_ff + 1'b1);
            if (KW'(r_ff + 1'b1) == mid_ff) lo_in = sort_head;
            if (r_ff == mid_ff) begin
               hi_in = sort_head;
               if (!even_ff) lo_in = sort_head;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= swmf_pkg::ST_IDLE;
         seen_ff    <= '0;
         pend_ff    <= '0;
         last_ff    <= 1'b0;
         head_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         seen_ff    <= seen_in;
         pend_ff    <= pend_in;
         last_ff    <= last_in;
         head_ff    <= head_in;
         rd_pend_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      cnt_ff      <= cnt_in;
      mid_ff      <= mid_in;
      even_ff     <= even_in;
      r_ff        <= r_in;
      res_last_ff <= res_last_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
   end

   // ---------------------------------------------------------------------------------
   // Output register: sum of the two middle ranks (or doubled middle)
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ok) begin
         rsp_median_ff <= {hi_ff[SAMPLE_BITS-1], hi_ff} + {lo_ff[SAMPLE_BITS-1], lo_ff};
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.median_x2   = rsp_median_ff;
   assign rsp_chan.last_result = rsp_last_ff;

   // ---------------------------------------------------------------------------------
   // Window store and sorter row
   swmf_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(MAX_WINDOW)
   ) u_store (
      .clock  (clock),
      .wr_en  (req_accept),
      .wr_addr(head_next),
      .wr_data(req_chan.sample),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   swmf_sort_chain #(
      .DEPTH(MAX_WINDOW),
      .WIDTH(SAMPLE_BITS)
   ) u_sorter (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sort_ctrl),
      .x         ($signed(rd_data)),
      .head_value(sort_head)
   );

endmodule
